@@ sv/sni_pkg.sv @@
`timescale 1ns / 1ps
package sni_pkg;

  // Record header (5) + handshake header (4) + version (2) = 11,
  // then random (32), session id length (1), session id (32).
  localparam logic [15:0] HEADER_BYTES = 16'(11 + 32 + 1 + 32);

  // Upper bound on the name length limit, independent of the register.
  localparam int unsigned MAX_NAME_BYTES = 256;
  localparam logic [8:0] NAME_CAP =
    9'((MAX_NAME_BYTES < 256) ? MAX_NAME_BYTES : 256);

  localparam logic [8:0] NAME_BUF_RESET = 9'd256;

  // Register map (byte address bit 2 selects the register slot).
  localparam logic REG_NAME_BUF_SIZE = 1'b0;

  typedef enum logic [3:0] {
    PH_HDR      = 4'd0,
    PH_CS_HI    = 4'd1,
    PH_CS_LO    = 4'd2,
    PH_SKIP_CS  = 4'd3,
    PH_SKIP4    = 4'd4,
    PH_ID_HI    = 4'd5,
    PH_ID_LO    = 4'd6,
    PH_LEN_HI   = 4'd7,
    PH_LEN_LO   = 4'd8,
    PH_SKIP_EXT = 4'd9,
    PH_LIST_HI  = 4'd10,
    PH_LIST_LO  = 4'd11,
    PH_TYPE     = 4'd12,
    PH_NLEN_HI  = 4'd13,
    PH_NLEN_LO  = 4'd14,
    PH_NAME     = 4'd15
  } phase_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       name_byte_valid;
    logic       done_res;
    logic       found;
    logic [7:0] name_length;
  } sni_result_t;

endpackage

@@ sv/sni_ifs.sv @@
`timescale 1ns / 1ps
interface sni_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface sni_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       name_byte_valid;
  logic       done_res;
  logic       found;
  logic [7:0] name_length;

  modport source (
    output valid, output name_byte, output name_byte_valid, output done_res,
    output found, output name_length, input ready
  );
  modport sink (
    input valid, input name_byte, input name_byte_valid, input done_res,
    input found, input name_length, output ready
  );
endinterface

@@ sv/sni_parser.sv @@
`timescale 1ns / 1ps
module sni_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 last,
  input  logic [8:0]           name_buffer_size,
  output logic                 emit,
  output sni_pkg::sni_result_t res
);
  import sni_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] ext_len, ext_len_next;
  logic [7:0]  field_hi, field_hi_next;
  logic        is_sni, is_sni_next;
  logic [7:0]  name_rem, name_rem_next;
  logic        finished, finished_next;

  logic [15:0] field16;
  logic [15:0] len16;
  logic [15:0] cnt_dec;
  logic [8:0]  limit;
  logic        fail, ok, nbv;
  logic [7:0]  nlen;

  assign field16 = {field_hi, data_byte};
  assign len16   = {ext_len[15:8], data_byte};
  assign cnt_dec = byte_count - 16'd1;
  assign limit   = (name_buffer_size > NAME_CAP) ? NAME_CAP : name_buffer_size;

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    ext_len_next    = ext_len;
    field_hi_next   = field_hi;
    is_sni_next     = is_sni;
    name_rem_next   = name_rem;
    finished_next   = finished;
    fail            = 1'b0;
    ok              = 1'b0;
    nbv             = 1'b0;
    nlen            = '0;
    emit            = 1'b0;

    if (!finished) begin
      unique case (phase)
        PH_HDR: begin
          byte_count_next = byte_count + 16'd1;
          if (byte_count_next >= HEADER_BYTES) phase_next = PH_CS_HI;
        end
        PH_CS_HI: begin
          field_hi_next = data_byte;
          phase_next    = PH_CS_LO;
        end
        PH_ID_HI: begin
          field_hi_next = data_byte;
          phase_next    = PH_ID_LO;
        end
        PH_LIST_HI: begin
          field_hi_next = data_byte;
          phase_next    = PH_LIST_LO;
        end
        PH_NLEN_HI: begin
          field_hi_next = data_byte;
          phase_next    = PH_NLEN_LO;
        end
        PH_CS_LO: begin
          if (field16 == 16'd0) begin
            byte_count_next = 16'd4;
            phase_next      = PH_SKIP4;
          end else begin
            byte_count_next = field16;
            phase_next      = PH_SKIP_CS;
          end
        end
        PH_SKIP_CS: begin
          byte_count_next = cnt_dec;
          if (cnt_dec == 16'd0) begin
            byte_count_next = 16'd4;
            phase_next      = PH_SKIP4;
          end
        end
        PH_SKIP4: begin
          byte_count_next = cnt_dec;
          if (cnt_dec == 16'd0) phase_next = PH_ID_HI;
        end
        PH_ID_LO: begin
          is_sni_next = (field_hi == 8'd0) && (data_byte == 8'd0);
          phase_next  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          ext_len_next = {data_byte, 8'd0};
          phase_next   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          ext_len_next = len16;
          if (is_sni) begin
            if (len16 < 16'd5) fail = 1'b1;
            else phase_next = PH_LIST_HI;
          end else if (len16 == 16'd0) begin
            phase_next = PH_ID_HI;
          end else begin
            byte_count_next = len16;
            phase_next      = PH_SKIP_EXT;
          end
        end
        PH_SKIP_EXT: begin
          byte_count_next = cnt_dec;
          if (cnt_dec == 16'd0) phase_next = PH_ID_HI;
        end
        PH_LIST_LO: begin
          if (field16 != ext_len - 16'd2) fail = 1'b1;
          else phase_next = PH_TYPE;
        end
        PH_TYPE: begin
          if (data_byte != 8'd0) fail = 1'b1;
          else phase_next = PH_NLEN_HI;
        end
        PH_NLEN_LO: begin
          // Length passes only below the limit (at most 255), so 8 bits hold it.
          name_rem_next = data_byte;
          if (field16 != ext_len - 16'd5 || field16 == 16'd0 ||
              field16 >= {7'd0, limit})
            fail = 1'b1;
          else phase_next = PH_NAME;
        end
        PH_NAME: begin
          if (data_byte == 8'd0) begin
            fail = 1'b1;
          end else begin
            nbv           = 1'b1;
            name_rem_next = name_rem - 8'd1;
            if (name_rem_next == 8'd0) begin
              ok   = 1'b1;
              nlen = 8'(ext_len - 16'd5);
            end
          end
        end
      endcase

      if (!ok && !fail && last) fail = 1'b1;
      emit = ok || fail || nbv;
      if ((ok || fail) && !last) finished_next = 1'b1;
    end

    // The final byte of a message always rearms the parser.
    if (last) begin
      phase_next      = PH_HDR;
      byte_count_next = '0;
      ext_len_next    = '0;
      field_hi_next   = '0;
      is_sni_next     = 1'b0;
      name_rem_next   = '0;
      finished_next   = 1'b0;
    end

    res.name_byte       = nbv ? data_byte : 8'd0;
    res.name_byte_valid = nbv;
    res.done_res        = ok || fail;
    res.found           = ok;
    res.name_length     = nlen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR;
      byte_count <= '0;
      ext_len    <= '0;
      field_hi   <= '0;
      is_sni     <= 1'b0;
      name_rem   <= '0;
      finished   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      ext_len    <= ext_len_next;
      field_hi   <= field_hi_next;
      is_sni     <= is_sni_next;
      name_rem   <= name_rem_next;
      finished   <= finished_next;
    end
  end

endmodule

@@ sv/sni_outq.sv @@
`timescale 1ns / 1ps
module sni_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sni_pkg::sni_result_t push_data,
  output logic                 full,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output sni_pkg::sni_result_t pop_data
);
  import sni_pkg::*;

  sni_result_t mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ sv/tls_sni_extractor.sv @@
`timescale 1ns / 1ps
// Streaming SNI extractor for a TLS ClientHello.
// byte_in: one message byte per beat, from the record header on; last marks
//   the final byte. A beat is taken when valid and ready are both high.
// result_out: zero or one beat per input byte. A beat carries a provisional
//   server-name byte, a done flag with found/name_length, or both (the final
//   name byte and the found report share one beat).
// APB: one register, name_buffer_size (offset 0x0, 9 bits, reset 256); a name
//   must be strictly shorter than it. Write only while the block is idle.
// Throughput: one byte per cycle while the output queue is not full; the
//   parser state updates in the cycle the byte is taken and the result is
//   registered in a two-beat output queue before it appears on result_out.
// Stall: the queue lets the block keep taking bytes while a result waits;
//   byte_in.ready drops only once two results are pending.
// Reset: parser returns to header skip, queue empties, register goes to 256.
// After done, further bytes are dropped until the byte with last, which rearms
//   the parser for the next message.
module tls_sni_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sni_in_if.sink      byte_in,
  sni_out_if.source   result_out
);
  import sni_pkg::*;

  logic [8:0]  name_buffer_size;
  logic        cfg_wr;
  logic        accept;
  logic        emit;
  logic        q_full;
  sni_result_t res;
  sni_result_t q_data;

  // APB: zero wait states, bit 2 of the byte address picks the register slot.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_NAME_BUF_SIZE) ? {23'd0, name_buffer_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_buffer_size <= NAME_BUF_RESET;
    end else if (cfg_wr && paddr[2] == REG_NAME_BUF_SIZE) begin
      name_buffer_size <= pwdata[8:0];
    end
  end

  // Input beat handshake; ready depends only on queue occupancy.
  assign byte_in.ready = ~q_full;
  assign accept        = byte_in.valid && ~q_full;

  sni_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .data_byte        (byte_in.data_byte),
    .last             (byte_in.last),
    .name_buffer_size (name_buffer_size),
    .emit             (emit),
    .res              (res)
  );

  sni_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && emit),
    .push_data (res),
    .full      (q_full),
    .pop_valid (result_out.valid),
    .pop_ready (result_out.ready),
    .pop_data  (q_data)
  );

  assign result_out.name_byte       = q_data.name_byte;
  assign result_out.name_byte_valid = q_data.name_byte_valid;
  assign result_out.done_res        = q_data.done_res;
  assign result_out.found           = q_data.found;
  assign result_out.name_length     = q_data.name_length;

endmodule
